>>> design/irss_pkg.sv
// Shared types, constants and microcode definitions for the IR receiver scan selector.
`default_nettype none

package irss_pkg;

    // Frame geometry
    localparam int X_COLUMNS = 30;
    localparam int Y_COLUMNS = 17;
    localparam int Y_POINTS  = 136;
    localparam int CHAIN_LEN = X_COLUMNS + Y_COLUMNS;

    // Field widths
    localparam int COL_W   = 6;
    localparam int ROW_W   = 4;
    localparam int ROW_BITS = 3;
    localparam int POINT_W = 8;
    localparam int PC_W    = 4;

    localparam logic [COL_W-1:0] CHAIN_LEN_C   = COL_W'(CHAIN_LEN);
    localparam logic [COL_W-1:0] COL_UNKNOWN_C = COL_W'(CHAIN_LEN + 1);
    localparam logic [ROW_W-1:0] ROW_NONE_C    = ROW_W'(8);
    localparam logic [ROW_BITS-1:0] ROW_MASK_C = ROW_BITS'(8'h07);

    // Input item
    typedef struct packed {
        logic               side;
        logic [POINT_W-1:0] point;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic                pulse;
        logic                shift_bit;
        logic [ROW_BITS-1:0] row_code;
        logic                row_changed;
        logic                range_error;
        logic                last;
    } out_item_t;

    typedef logic [PC_W-1:0] pc_t;

    // Microcode fields
    typedef enum logic [2:0] {
        OP_WAIT  = 3'd0,
        OP_NOP   = 3'd1,
        OP_LOAD  = 3'd2,
        OP_RUN   = 3'd3,
        OP_FINAL = 3'd4,
        OP_ERROR = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        SRC_CHAIN = 3'd0,
        SRC_DIFF  = 3'd1,
        SRC_TOP   = 3'd2,
        SRC_ONE   = 3'd3,
        SRC_COL   = 3'd4
    } cnt_src_t;

    typedef enum logic [1:0] {
        BIT_ONE   = 2'd0,
        BIT_ZERO  = 2'd1,
        BIT_MATCH = 2'd2
    } bit_src_t;

    typedef enum logic [2:0] {
        COND_NEVER  = 3'd0,
        COND_ALWAYS = 3'd1,
        COND_ERR    = 3'd2,
        COND_FULL   = 3'd3,
        COND_GT     = 3'd4,
        COND_EQ     = 3'd5
    } cond_t;

    typedef struct packed {
        op_t      op;
        cnt_src_t cnt_src;
        bit_src_t bit_src;
        cond_t    cond;
        pc_t      target;
    } ucode_t;

    // Program addresses
    localparam pc_t PC_WAIT    = PC_W'(0);
    localparam pc_t PC_CHK_ERR = PC_W'(1);
    localparam pc_t PC_CHK_FUL = PC_W'(2);
    localparam pc_t PC_CHK_GT  = PC_W'(3);
    localparam pc_t PC_CHK_EQ  = PC_W'(4);
    localparam pc_t PC_LD_TOP  = PC_W'(5);
    localparam pc_t PC_RUN_TOP = PC_W'(6);
    localparam pc_t PC_LD_WRAP = PC_W'(7);
    localparam pc_t PC_RUN_WRP = PC_W'(8);
    localparam pc_t PC_LD_COL  = PC_W'(9);
    localparam pc_t PC_RUN_FUL = PC_W'(10);
    localparam pc_t PC_RUN_ONE = PC_W'(11);
    localparam pc_t PC_FINAL   = PC_W'(12);
    localparam pc_t PC_ERROR   = PC_W'(13);

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic err;
        logic full;
        logic gt;
        logic eq;
        logic cnt_zero;
        logic emit_ok;
    } dp_status_t;

endpackage

`default_nettype wire

>>> design/ir_receiver_scan_select.sv
// Order: an error result is registered from the error step that follows the error check; other
// points pass the check and load steps before their first result, then one per pulse, one final.
// Throughput: one point at a time; a full chain rewrite shifts 47 pulses, the wrap path up to
// 47 pulses plus its extra load and zero-check steps.
// Pulse rate: one per cycle unless stalled, set by microcode counter step and result register.
// Reset: chain column unknown (first point rewrites the whole chain), no row, reload mode off.
`default_nettype none

module ir_receiver_scan_select
    import irss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    pc_t        pc_reg, pc_next;
    ucode_t     word;
    dp_status_t status;
    logic       reload_reg;
    logic       item_load;
    logic       cond_hit;
    logic       step_done;

    irss_ucode_rom u_rom (
        .pc   (pc_reg),
        .word (word)
    );

    irss_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_load    (item_load),
        .item         (item),
        .word         (word),
        .reload_mode  (reload_reg),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Input transfer only while the program sits at its wait step
    assign item_stall = (word.op != OP_WAIT);
    assign item_load  = item_valid && !item_stall;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            reload_reg <= cfg_data;
        end
    end

    // Jump condition
    always_comb
    begin
        case (word.cond)
            COND_NEVER:  cond_hit = 1'b0;
            COND_ALWAYS: cond_hit = 1'b1;
            COND_ERR:    cond_hit = status.err;
            COND_FULL:   cond_hit = status.full;
            COND_GT:     cond_hit = status.gt;
            COND_EQ:     cond_hit = status.eq;
            default:     cond_hit = 1'b0;
        endcase
    end

    // Step completion per operation
    always_comb
    begin
        case (word.op)
            OP_WAIT:  step_done = item_load;
            OP_NOP:   step_done = 1'b1;
            OP_LOAD:  step_done = 1'b1;
            OP_RUN:   step_done = status.cnt_zero;
            OP_FINAL: step_done = status.emit_ok;
            OP_ERROR: step_done = status.emit_ok;
            default:  step_done = 1'b1;
        endcase
    end

    // Step counter
    always_comb
    begin
        pc_next = pc_reg;
        if (step_done)
        begin
            pc_next = cond_hit ? word.target : pc_reg + PC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

>>> design/irss_ucode_rom.sv
// Read-only control store: one microcode word per program step.
`default_nettype none

module irss_ucode_rom
    import irss_pkg::*;
(
    input  pc_t    pc,
    output ucode_t word
);

    always_comb
    begin
        case (pc)
            PC_WAIT:    word = '{OP_WAIT,  SRC_CHAIN, BIT_ONE,   COND_NEVER,  PC_WAIT};
            PC_CHK_ERR: word = '{OP_NOP,   SRC_CHAIN, BIT_ONE,   COND_ERR,    PC_ERROR};
            PC_CHK_FUL: word = '{OP_LOAD,  SRC_CHAIN, BIT_ONE,   COND_FULL,   PC_RUN_FUL};
            PC_CHK_GT:  word = '{OP_LOAD,  SRC_DIFF,  BIT_ONE,   COND_GT,     PC_RUN_ONE};
            PC_CHK_EQ:  word = '{OP_NOP,   SRC_CHAIN, BIT_ONE,   COND_EQ,     PC_FINAL};
            PC_LD_TOP:  word = '{OP_LOAD,  SRC_TOP,   BIT_ONE,   COND_NEVER,  PC_WAIT};
            PC_RUN_TOP: word = '{OP_RUN,   SRC_CHAIN, BIT_ONE,   COND_NEVER,  PC_WAIT};
            PC_LD_WRAP: word = '{OP_LOAD,  SRC_ONE,   BIT_ONE,   COND_NEVER,  PC_WAIT};
            PC_RUN_WRP: word = '{OP_RUN,   SRC_CHAIN, BIT_ZERO,  COND_NEVER,  PC_WAIT};
            PC_LD_COL:  word = '{OP_LOAD,  SRC_COL,   BIT_ONE,   COND_ALWAYS, PC_RUN_ONE};
            PC_RUN_FUL: word = '{OP_RUN,   SRC_CHAIN, BIT_MATCH, COND_ALWAYS, PC_FINAL};
            PC_RUN_ONE: word = '{OP_RUN,   SRC_CHAIN, BIT_ONE,   COND_NEVER,  PC_WAIT};
            PC_FINAL:   word = '{OP_FINAL, SRC_CHAIN, BIT_ONE,   COND_ALWAYS, PC_WAIT};
            PC_ERROR:   word = '{OP_ERROR, SRC_CHAIN, BIT_ONE,   COND_ALWAYS, PC_WAIT};
            default:    word = '{OP_ERROR, SRC_CHAIN, BIT_ONE,   COND_ALWAYS, PC_WAIT};
        endcase
    end

endmodule

`default_nettype wire

>>> design/irss_datapath.sv
// Decode, pulse counter, selection state and result register.
`default_nettype none

module irss_datapath
    import irss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_load,
    input  in_item_t   item,
    input  ucode_t     word,
    input  logic       reload_mode,
    output dp_status_t status,
    output logic       result_valid,
    input  logic       result_stall,
    output out_item_t  result
);

    localparam logic [4:0] X_COLS_C  = 5'(X_COLUMNS);
    localparam logic [4:0] Y_COLS_C  = 5'(Y_COLUMNS);
    localparam logic [POINT_W-1:0] Y_POINTS_C = POINT_W'(Y_POINTS);
    localparam logic [POINT_W-1:0] Y_LAST_C   = POINT_W'(Y_POINTS - 1);

    logic [POINT_W-1:0]  y_p;
    logic [4:0]          y_colw;
    logic [4:0]          x_colw;
    logic                dec_err;
    logic [COL_W-1:0]    dec_col;
    logic [ROW_BITS-1:0] dec_row;

    logic [COL_W-1:0]    col_reg;
    logic [ROW_BITS-1:0] row_reg;
    logic                err_reg;
    logic [COL_W-1:0]    sel_col_reg, sel_col_next;
    logic [ROW_W-1:0]    sel_row_reg, sel_row_next;
    logic [COL_W-1:0]    cnt_reg, cnt_next;
    logic                valid_reg, valid_next;
    out_item_t           out_reg, out_next;

    logic                emit_ok;
    logic                cnt_zero;
    logic [COL_W-1:0]    cnt_idx;
    logic                run_bit;
    logic                row_changed;

    // Point decode: mirror Y, split into column and row
    always_comb
    begin
        y_p    = Y_LAST_C - item.point;
        y_colw = y_p[POINT_W-1:ROW_BITS];
        x_colw = item.point[POINT_W-1:ROW_BITS];
        if (item.side)
        begin
            dec_err = (item.point >= Y_POINTS_C) || (y_colw >= Y_COLS_C);
            dec_col = {1'b0, y_colw};
            dec_row = y_p[ROW_BITS-1:0] & ROW_MASK_C;
        end
        else
        begin
            dec_err = (x_colw >= X_COLS_C);
            dec_col = COL_W'(Y_COLUMNS) + {1'b0, x_colw};
            dec_row = item.point[ROW_BITS-1:0] & ROW_MASK_C;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_load)
        begin
            col_reg <= dec_col;
            row_reg <= dec_row;
            err_reg <= dec_err;
        end
    end

    // Branch conditions
    assign emit_ok  = !valid_reg || !result_stall;
    assign cnt_zero = (cnt_reg == '0);
    assign cnt_idx  = cnt_reg - COL_W'(1);

    always_comb
    begin
        status.err      = err_reg;
        status.full     = (sel_col_reg == COL_UNKNOWN_C) ||
                          (reload_mode && (col_reg != sel_col_reg));
        status.gt       = (col_reg > sel_col_reg);
        status.eq       = (col_reg == sel_col_reg);
        status.cnt_zero = cnt_zero;
        status.emit_ok  = emit_ok;
    end

    // Shifted data level
    always_comb
    begin
        case (word.bit_src)
            BIT_ONE:   run_bit = 1'b1;
            BIT_ZERO:  run_bit = 1'b0;
            BIT_MATCH: run_bit = (cnt_idx != col_reg);
            default:   run_bit = 1'b1;
        endcase
    end

    assign row_changed = ({1'b0, row_reg} != sel_row_reg);

    // Counter, state and result register updates
    always_comb
    begin
        cnt_next     = cnt_reg;
        sel_col_next = sel_col_reg;
        sel_row_next = sel_row_reg;
        valid_next   = valid_reg && result_stall;
        out_next     = out_reg;
        case (word.op)
            OP_LOAD:
            begin
                case (word.cnt_src)
                    SRC_CHAIN: cnt_next = CHAIN_LEN_C;
                    SRC_DIFF:  cnt_next = col_reg - sel_col_reg;
                    SRC_TOP:   cnt_next = CHAIN_LEN_C - sel_col_reg;
                    SRC_ONE:   cnt_next = COL_W'(1);
                    SRC_COL:   cnt_next = col_reg;
                    default:   cnt_next = '0;
                endcase
            end
            OP_RUN:
            begin
                if (!cnt_zero && emit_ok)
                begin
                    cnt_next   = cnt_idx;
                    valid_next = 1'b1;
                    out_next   = '{1'b1, run_bit, '0, 1'b0, 1'b0, 1'b0};
                end
            end
            OP_FINAL:
            begin
                if (emit_ok)
                begin
                    sel_col_next = col_reg;
                    sel_row_next = {1'b0, row_reg};
                    valid_next   = 1'b1;
                    out_next     = '{1'b0, 1'b0, row_reg ^ (row_reg >> 1),
                                     row_changed, 1'b0, 1'b1};
                end
            end
            OP_ERROR:
            begin
                if (emit_ok)
                begin
                    valid_next = 1'b1;
                    out_next   = '{1'b0, 1'b0, '0, 1'b0, 1'b1, 1'b1};
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            sel_col_reg <= COL_UNKNOWN_C;
            sel_row_reg <= ROW_NONE_C;
            valid_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            sel_col_reg <= sel_col_next;
            sel_row_reg <= sel_row_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire
